// ----- sv/pls_pkg.sv -----
// Package for the positional list store: word types, mode codes, shared constants.
`default_nettype none
package pls_pkg;

   localparam int CAPACITY_DEFAULT = 64;

   localparam int MODE_W     = 3;
   localparam int POSITION_W = 7;
   localparam int VALUE_W    = 32;
   localparam int COUNT_W    = 7;

   localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd1;
   localparam logic [MODE_W-1:0] MODE_READ   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_WRITE  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

   localparam logic signed [VALUE_W-1:0] READ_FAIL_VALUE = -32'sd1;

   typedef struct packed {
      logic [MODE_W-1:0]            mode;
      logic [POSITION_W-1:0]        position;
      logic signed [VALUE_W-1:0]    value;
   } req_type;

   typedef struct packed {
      logic                         ok;
      logic signed [VALUE_W-1:0]    read_value;
      logic [COUNT_W-1:0]           count;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;      // capture request word
      logic execute;   // apply operation, build response word
   } ctrl_cmd_type;

endpackage
`default_nettype wire

// ----- sv/pls_ctrl.sv -----
// Controller state machine for the positional list store.
`default_nettype none
module pls_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output pls_pkg::ctrl_cmd_type   cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_RESP = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = (state_ff == ST_RESP);
   assign cmd.load    = req_valid && req_ready;
   assign cmd.execute = (state_ff == ST_EXEC);

endmodule
`default_nettype wire

// ----- sv/pls_datapath.sv -----
// Datapath: row of entry cells, entry count, legality checks and response word.
`default_nettype none
module pls_datapath #(
   parameter int CAPACITY = pls_pkg::CAPACITY_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire pls_pkg::ctrl_cmd_type cmd,
   input  wire pls_pkg::req_type      req_data,
   output pls_pkg::rsp_type           rsp_data
);

   localparam int CW = $clog2(CAPACITY + 1);
   // wide enough for position, count+1 and every cell index
   localparam int W  = ((CW > pls_pkg::POSITION_W) ? CW : pls_pkg::POSITION_W) + 1;
   localparam logic [W-1:0] CAP_W = W'(CAPACITY);
   localparam logic [W-1:0] ONE_W = W'(1);

   pls_pkg::req_type req_ff;
   pls_pkg::rsp_type rsp_ff;
   logic [CW-1:0]    count_ff;
   logic [CW-1:0]    count_in;

   logic signed [pls_pkg::VALUE_W-1:0] entries_ff [CAPACITY];
   logic signed [pls_pkg::VALUE_W-1:0] entries_in [CAPACITY];

   logic [W-1:0] pos_w, pos0_w, cnt_w;
   logic         pos_nonzero, in_range, ins_legal;
   logic         do_insert, do_remove, do_write, do_clear;
   logic         ok;
   logic signed [pls_pkg::VALUE_W-1:0] rd_sel, rd_value;
   logic [W-1:0] cnt_next_w;

   always_comb begin
      pos_w       = W'(req_ff.position);
      pos0_w      = pos_w - ONE_W;
      cnt_w       = W'(count_ff);
      pos_nonzero = (pos_w != '0);
      in_range    = pos_nonzero && (pos_w <= cnt_w);
      ins_legal   = pos_nonzero && (pos_w <= cnt_w + ONE_W) && (cnt_w < CAP_W);
   end

   always_comb begin
      do_insert = 1'b0;
      do_remove = 1'b0;
      do_write  = 1'b0;
      do_clear  = 1'b0;
      ok        = 1'b0;
      rd_value  = '0;
      unique case (req_ff.mode)
         pls_pkg::MODE_INSERT: begin
            do_insert = ins_legal;
            ok        = ins_legal;
         end
         pls_pkg::MODE_REMOVE: begin
            do_remove = in_range;
            ok        = in_range;
         end
         pls_pkg::MODE_READ: begin
            ok       = in_range;
            rd_value = in_range ? rd_sel : pls_pkg::READ_FAIL_VALUE;
         end
         pls_pkg::MODE_WRITE: begin
            do_write = in_range;
            ok       = in_range;
         end
         pls_pkg::MODE_CLEAR: begin
            do_clear = 1'b1;
            ok       = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (do_insert)      count_in = count_ff + CW'(1);
      else if (do_remove) count_in = count_ff - CW'(1);
      else if (do_clear)  count_in = '0;
      cnt_next_w = W'(count_in);
   end

   // selected entry for read; cells are picked by their own compare
   always_comb begin
      rd_sel = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (pos0_w == W'(i)) rd_sel = rd_sel | entries_ff[i];
      end
   end

   // each cell takes its neighbor on a shift, the request value on a hit
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      localparam logic [W-1:0] IDX = W'(i);
      always_comb begin
         entries_in[i] = entries_ff[i];
         if ((do_insert || do_write) && (IDX == pos0_w)) begin
            entries_in[i] = req_ff.value;
         end else if (do_insert && (IDX > pos0_w)) begin
            if (i > 0) entries_in[i] = entries_ff[(i > 0) ? i - 1 : 0];
         end else if (do_remove && (IDX >= pos0_w)) begin
            if (i < CAPACITY - 1) entries_in[i] = entries_ff[(i < CAPACITY - 1) ? i + 1 : i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_data;
      if (cmd.execute) begin
         for (int i = 0; i < CAPACITY; i++) entries_ff[i] <= entries_in[i];
         rsp_ff.ok         <= ok;
         rsp_ff.read_value <= rd_value;
         rsp_ff.count      <= cnt_next_w[pls_pkg::COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset)            count_ff <= '0;
      else if (cmd.execute) count_ff <= count_in;
   end

   assign rsp_data = rsp_ff;

endmodule
`default_nettype wire

// ----- sv/positional_list_store.sv -----
// Top level of the positional list store: controller plus datapath.
//
// Ordered list of signed 32-bit entries at 1-based positions, up to CAPACITY.
// Request channel (req_valid/req_ready/req_data) takes one word per operation:
// mode (insert, remove, read, write, clear), position and value.
// Response channel (rsp_valid/rsp_ready/rsp_data) returns exactly one word per
// request: ok, read_value (entry on a good read, -1 on a failed read, else 0)
// and the entry count after the operation.
// Sequencing: an accepted request is captured in the request register,
// applied to the cell row in the execute state, and the response word is
// registered and valid in the response state that follows. The controller
// takes one request at a time and accepts no new one until the response
// has been taken. The cell row shifts every entry at once, so list length
// does not affect timing.
// While rsp_valid is high and rsp_ready is low the response word holds and
// req_ready stays low.
// Reset empties the list (count zero); entry contents are not cleared and
// are never visible before being written.
`default_nettype none
module positional_list_store #(
   parameter int CAPACITY = pls_pkg::CAPACITY_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire pls_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output pls_pkg::rsp_type      rsp_data
);

   pls_pkg::ctrl_cmd_type cmd;

   // sequencing: idle, execute, present response
   pls_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // cells, count and response register
   pls_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule
`default_nettype wire

// ----- tb/sv/positional_list_store_tb.sv -----
// Self-checking testbench for the positional list store: directed table plus random list traffic.
`default_nettype none
module positional_list_store_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY     = pls_pkg::CAPACITY_DEFAULT;
   localparam int RANDOM_OPS   = 600;   // random words that touch the list
   localparam int QUIET_LIMIT  = 2000;  // cycles with no handshake before giving up
   localparam int DRAIN_CYCLES = 10;    // idle cycles after the last owed response
   localparam int HOLD_CYCLES  = 80;    // long receiver back-off, stalls the block
   localparam int HOLD_AT      = 200;   // responses seen before the back-off starts

   // spare mode codes, ignored by the block
   localparam logic [pls_pkg::MODE_W-1:0] MODE_SPARE_LO = 3'd5;
   localparam logic [pls_pkg::MODE_W-1:0] MODE_SPARE_HI = 3'd7;

   localparam logic signed [pls_pkg::VALUE_W-1:0] VALUE_MAX = 32'sh7fff_ffff;
   localparam logic signed [pls_pkg::VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   pls_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   pls_pkg::rsp_type rsp_data;

   always #1 clock = ~clock;

   positional_list_store dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // -------------------------------------------------------------------------
   // Shadow list. Only the live entries are kept: a clear drops them all,
   // which is the same as the block since stale entries are never visible.
   // -------------------------------------------------------------------------
   logic signed [pls_pkg::VALUE_W-1:0] shadow_list[$];
   pls_pkg::rsp_type                   awaited_rsp[$];   // responses still owed, oldest first

   int mismatches  = 0;
   int words_in    = 0;
   int rsp_seen    = 0;
   int full_hits   = 0;
   int empty_hits  = 0;
   bit sender_calm = 1'b0;

   function automatic pls_pkg::rsp_type list_apply(input pls_pkg::req_type w);
      pls_pkg::rsp_type r;
      int unsigned      p;
      int unsigned      n;
      r = '0;
      p = w.position;
      n = shadow_list.size();
      case (w.mode)
         pls_pkg::MODE_INSERT: begin
            if (p >= 1 && p <= n + 1 && n < CAPACITY) begin
               shadow_list.insert(p - 1, w.value);
               r.ok = 1'b1;
            end
         end
         pls_pkg::MODE_REMOVE: begin
            if (p >= 1 && p <= n) begin
               shadow_list.delete(p - 1);
               r.ok = 1'b1;
            end
         end
         pls_pkg::MODE_READ: begin
            if (p >= 1 && p <= n) begin
               r.read_value = shadow_list[p - 1];
               r.ok = 1'b1;
            end else begin
               r.read_value = pls_pkg::READ_FAIL_VALUE;
            end
         end
         pls_pkg::MODE_WRITE: begin
            if (p >= 1 && p <= n) begin
               shadow_list[p - 1] = w.value;
               r.ok = 1'b1;
            end
         end
         pls_pkg::MODE_CLEAR: begin
            shadow_list.delete();
            r.ok = 1'b1;
         end
         default: ;   // spare codes: no change, ok low
      endcase
      r.count = pls_pkg::COUNT_W'(shadow_list.size());
      return r;
   endfunction

   // Offer one word, holding valid and payload until the handshake. On
   // acceptance the shadow list advances and the owed response is queued;
   // a typed-in response, where given, is what gets checked.
   task automatic offer(input pls_pkg::req_type w, input bit typed,
                        input pls_pkg::rsp_type golden);
      int               gap;
      pls_pkg::rsp_type want;
      gap = 0;
      if (!sender_calm && $urandom_range(99) < 36)
         gap = $urandom_range(1, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      words_in++;
      want = list_apply(w);
      if (w.mode == pls_pkg::MODE_INSERT && want.ok &&
          want.count == pls_pkg::COUNT_W'(CAPACITY))
         full_hits++;
      if ((w.mode == pls_pkg::MODE_REMOVE || w.mode == pls_pkg::MODE_CLEAR) &&
          want.ok && want.count == '0)
         empty_hits++;
      awaited_rsp.push_back(typed ? golden : want);
   endtask

   // -------------------------------------------------------------------------
   // Directed table. Rows with typed set carry a response read straight off
   // the list contents; the rest are checked against the shadow list.
   // -------------------------------------------------------------------------
   typedef struct packed {
      logic [pls_pkg::MODE_W-1:0]         mode;
      logic [pls_pkg::POSITION_W-1:0]     position;
      logic signed [pls_pkg::VALUE_W-1:0] value;
      bit                                 typed;
      logic                               ok;
      logic signed [pls_pkg::VALUE_W-1:0] read_value;
      logic [pls_pkg::COUNT_W-1:0]        count;
   } script_row_type;

   localparam int SCRIPT_LEN = 25;

   script_row_type script [SCRIPT_LEN] = '{
      // empty list: read, remove and write all fail
      '{pls_pkg::MODE_READ,   7'd1,   32'sd0,         1'b1, 1'b0,
        pls_pkg::READ_FAIL_VALUE, 7'd0},
      '{pls_pkg::MODE_REMOVE, 7'd1,   32'sd0,         1'b1, 1'b0, 32'sd0,    7'd0},
      '{pls_pkg::MODE_WRITE,  7'd1,   32'sd5,         1'b1, 1'b0, 32'sd0,    7'd0},
      // position zero, and insert past count+1
      '{pls_pkg::MODE_INSERT, 7'd0,   32'sd9,         1'b1, 1'b0, 32'sd0,    7'd0},
      '{pls_pkg::MODE_INSERT, 7'd2,   32'sd9,         1'b1, 1'b0, 32'sd0,    7'd0},
      // build [min, max, -1], then slot a pattern into the middle
      '{pls_pkg::MODE_INSERT, 7'd1,   VALUE_MAX,      1'b1, 1'b1, 32'sd0,    7'd1},
      '{pls_pkg::MODE_INSERT, 7'd1,   VALUE_MIN,      1'b1, 1'b1, 32'sd0,    7'd2},
      '{pls_pkg::MODE_INSERT, 7'd3,   -32'sd1,        1'b1, 1'b1, 32'sd0,    7'd3},
      '{pls_pkg::MODE_INSERT, 7'd2,   32'sh5555_5555, 1'b0, 1'b0, 32'sd0,    7'd0},
      // reads: first, last (holds -1 but ok), zero, all-ones, one past end
      '{pls_pkg::MODE_READ,   7'd1,   32'sd0,         1'b1, 1'b1, VALUE_MIN, 7'd4},
      '{pls_pkg::MODE_READ,   7'd4,   32'sd0,         1'b1, 1'b1, -32'sd1,   7'd4},
      '{pls_pkg::MODE_READ,   7'd0,   32'sd0,         1'b1, 1'b0,
        pls_pkg::READ_FAIL_VALUE, 7'd4},
      '{pls_pkg::MODE_READ,   7'd127, 32'sd0,         1'b1, 1'b0,
        pls_pkg::READ_FAIL_VALUE, 7'd4},
      '{pls_pkg::MODE_READ,   7'd5,   32'sd0,         1'b1, 1'b0,
        pls_pkg::READ_FAIL_VALUE, 7'd4},
      '{pls_pkg::MODE_WRITE,  7'd2,   32'shaaaa_aaaa, 1'b0, 1'b0, 32'sd0,    7'd0},
      '{pls_pkg::MODE_READ,   7'd2,   32'sd0,         1'b0, 1'b0, 32'sd0,    7'd0},
      // remove head, then tail
      '{pls_pkg::MODE_REMOVE, 7'd1,   32'sd0,         1'b0, 1'b0, 32'sd0,    7'd0},
      '{pls_pkg::MODE_REMOVE, 7'd3,   32'sd0,         1'b0, 1'b0, 32'sd0,    7'd0},
      '{pls_pkg::MODE_REMOVE, 7'd3,   32'sd0,         1'b1, 1'b0, 32'sd0,    7'd2},
      '{pls_pkg::MODE_WRITE,  7'd3,   32'sd1,         1'b1, 1'b0, 32'sd0,    7'd2},
      // spare codes do nothing
      '{MODE_SPARE_LO,        7'd1,   32'sd1,         1'b1, 1'b0, 32'sd0,    7'd2},
      '{MODE_SPARE_HI,        7'd127, -32'sd1,        1'b1, 1'b0, 32'sd0,    7'd2},
      // clear, then the list behaves as fresh
      '{pls_pkg::MODE_CLEAR,  7'd0,   32'sd0,         1'b1, 1'b1, 32'sd0,    7'd0},
      '{pls_pkg::MODE_READ,   7'd1,   32'sd0,         1'b1, 1'b0,
        pls_pkg::READ_FAIL_VALUE, 7'd0},
      '{pls_pkg::MODE_INSERT, 7'd1,   32'sh1234_5678, 1'b1, 1'b1, 32'sd0,    7'd1}
   };

   // -------------------------------------------------------------------------
   // Sender: reset, directed table, then random traffic that swings the list
   // between empty and full so both boundaries get hit repeatedly.
   // -------------------------------------------------------------------------
   initial begin
      pls_pkg::req_type w;
      pls_pkg::rsp_type golden;
      int               live_ops;
      int               n;
      int               pick;
      bit               growing;
      bit               spare;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int k = 0; k < SCRIPT_LEN; k++) begin
         w.mode            = script[k].mode;
         w.position        = script[k].position;
         w.value           = script[k].value;
         golden.ok         = script[k].ok;
         golden.read_value = script[k].read_value;
         golden.count      = script[k].count;
         offer(w, script[k].typed, golden);
      end

      live_ops = 0;
      growing  = 1'b1;
      golden   = '0;
      while (live_ops < RANDOM_OPS) begin
         n     = shadow_list.size();
         spare = 1'b0;
         // a quiet stretch in the middle: sender never pauses
         sender_calm = (live_ops >= 350 && live_ops < 450);
         // once full, linger a few words so full-list inserts get tried
         if (n == CAPACITY && $urandom_range(99) < 30)
            growing = 1'b0;
         if (n == 0)
            growing = 1'b1;

         pick = $urandom_range(99);
         if ($urandom_range(199) == 0)
            w.mode = pls_pkg::MODE_CLEAR;
         else if (pick < (growing ? 60 : 10))
            w.mode = pls_pkg::MODE_INSERT;
         else if (pick < (growing ? 70 : 60))
            w.mode = pls_pkg::MODE_REMOVE;
         else if (pick < 82)
            w.mode = pls_pkg::MODE_READ;
         else if (pick < 97)
            w.mode = pls_pkg::MODE_WRITE;
         else begin
            w.mode = pls_pkg::MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
            spare  = 1'b1;
         end

         // mostly legal positions, some anywhere in the field
         if ($urandom_range(99) < 15)
            w.position = pls_pkg::POSITION_W'($urandom_range(0, 127));
         else if (w.mode == pls_pkg::MODE_INSERT)
            w.position = pls_pkg::POSITION_W'($urandom_range(1, n + 1));
         else
            w.position = pls_pkg::POSITION_W'((n == 0) ? 1 : $urandom_range(1, n));

         case ($urandom_range(9))
            0:       w.value = VALUE_MIN;
            1:       w.value = VALUE_MAX;
            2:       w.value = '0;
            3:       w.value = -32'sd1;
            default: w.value = pls_pkg::VALUE_W'($urandom);
         endcase

         offer(w, 1'b0, golden);
         if (!spare)
            live_ops++;
      end
      req_valid <= 1'b0;

      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d words, checked %0d responses, mismatches %0d.",
               words_in, rsp_seen, mismatches);
      $display("List filled to capacity %0d times and drained to empty %0d times.",
               full_hits, empty_hits);
      if (mismatches == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Receiver: checks each accepted response against the oldest owed one,
   // and drives rsp_ready with random stalls, one long hold-off that backs
   // the block up, and a stretch with no stalls at all.
   // -------------------------------------------------------------------------
   initial begin
      pls_pkg::rsp_type want;
      pls_pkg::rsp_type got;
      int               hold;
      bit               held;
      hold = 0;
      held = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            rsp_seen++;
            if (awaited_rsp.size() == 0) begin
               $display("%0t: response word with nothing owed: ok %0b value %0d count %0d",
                        $realtime, got.ok, got.read_value, got.count);
               mismatches++;
            end else begin
               want = awaited_rsp.pop_front();
               if (got.ok !== want.ok) begin
                  $display("%0t: ok mismatch, expected %0b, got %0b",
                           $realtime, want.ok, got.ok);
                  mismatches++;
               end
               if (got.read_value !== want.read_value) begin
                  $display("%0t: read_value mismatch, expected %0d, got %0d",
                           $realtime, want.read_value, got.read_value);
                  mismatches++;
               end
               if (got.count !== want.count) begin
                  $display("%0t: count mismatch, expected %0d, got %0d",
                           $realtime, want.count, got.count);
                  mismatches++;
               end
            end
         end

         if (!held && rsp_seen == HOLD_AT) begin
            held = 1'b1;
            hold = HOLD_CYCLES;
         end
         if (hold > 0) begin
            hold--;
            rsp_ready <= 1'b0;
         end else if (rsp_seen >= 380 && rsp_seen < 480) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= 36);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Watchdog: too long without any handshake means the block is hung.
   // -------------------------------------------------------------------------
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $realtime, QUIET_LIMIT);
         $display("Test completed with failures");
         $finish;
      end
   end

endmodule
`default_nettype wire

// ----- sim.f -----
sv/pls_pkg.sv
sv/pls_ctrl.sv
sv/pls_datapath.sv
sv/positional_list_store.sv
tb/sv/positional_list_store_tb.sv
